// ===== design/scli_pkg.sv =====
package scli_pkg;

  localparam int LINE_CAPACITY_DEF = 16;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // the line is scanned over at most this many positions for command matching
  localparam int SCAN_MAX = 8;
  localparam int SCAN_W   = $clog2(SCAN_MAX);

  localparam int CMD_ON_LEN   = 6;
  localparam int CMD_OFF_LEN  = 7;
  localparam int CMD_HELP_LEN = 4;

  // command text padded with zero so that the position just past the end must hold zero
  localparam logic [7:0] CMD_ON_TEXT [SCAN_MAX] =
    '{"L", "E", "D", "_", "O", "N", 8'h00, 8'h00};
  localparam logic [7:0] CMD_OFF_TEXT [SCAN_MAX] =
    '{"L", "E", "D", "_", "O", "F", "F", 8'h00};
  localparam logic [7:0] CMD_HELP_TEXT [SCAN_MAX] =
    '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00};

  localparam int ROM_LEN = 181;
  localparam int ROM_AW  = $clog2(ROM_LEN);
  localparam int MAX_RUN = 61;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  // each reply but the erase sequence is followed by its prompt so that one run covers it
  localparam logic [8*ROM_LEN-1:0] MSG_ROM = {
    "\015\012OK: LED ON\015\012Ready > ",
    "\015\012OK: LED OFF\015\012Ready > ",
    "\015\012--- MENU ---\015\012LED_ON\015\012LED_OFF\015\012HELP\015\012",
    "------------\015\012Ready > ",
    "\015\012ERROR: Unknown command\015\012Ready > ",
    "\015\012Ready > ",
    "\015\012ERROR: Too long!\015\012Ready > ",
    "\010 \010"
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESULT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MSG_ECHO,
    MSG_ON,
    MSG_OFF,
    MSG_HELP,
    MSG_UNKNOWN,
    MSG_NEWPROMPT,
    MSG_TOOLONG,
    MSG_ERASE
  } msg_t;

  typedef struct packed {
    logic load_rx;
    logic store;
    logic erase;
    logic clear_fill;
    logic scan_init;
    logic scan_chk;
    logic scan_next;
    logic led_set;
    logic led_clr;
    logic emit_start;
    msg_t emit_msg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_bs;
    logic is_eol;
    logic fill_zero;
    logic room;
    logic scan_done;
    logic match_on;
    logic match_off;
    logic match_help;
    logic emit_busy;
  } dp_status_t;

  function automatic logic [ROM_AW-1:0] msg_offset(input msg_t msg);
    logic [ROM_AW-1:0] off;
    unique case (msg)
      MSG_ON:        off = ROM_AW'(0);
      MSG_OFF:       off = ROM_AW'(22);
      MSG_HELP:      off = ROM_AW'(45);
      MSG_UNKNOWN:   off = ROM_AW'(106);
      MSG_NEWPROMPT: off = ROM_AW'(140);
      MSG_TOOLONG:   off = ROM_AW'(150);
      MSG_ERASE:     off = ROM_AW'(178);
      default:       off = ROM_AW'(0);
    endcase
    return off;
  endfunction

  function automatic logic [RUN_W-1:0] msg_len(input msg_t msg);
    logic [RUN_W-1:0] len;
    unique case (msg)
      MSG_ON:        len = RUN_W'(22);
      MSG_OFF:       len = RUN_W'(23);
      MSG_HELP:      len = RUN_W'(61);
      MSG_UNKNOWN:   len = RUN_W'(34);
      MSG_NEWPROMPT: len = RUN_W'(10);
      MSG_TOOLONG:   len = RUN_W'(28);
      MSG_ERASE:     len = RUN_W'(3);
      default:       len = RUN_W'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] idx);
    return MSG_ROM[8*(ROM_LEN-1-int'(idx)) +: 8];
  endfunction

endpackage

// ===== design/serial_command_line_interpreter_core.sv =====
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  rx_char
// output   out        out_valid/ out_stall tx_char, last_char, led_state
//
// a request is taken only in idle; the next one waits until its run of n bytes is loaded
// a line end with text first scans up to min(fill, 8) positions, then picks the reply
// a backspace on an empty line gives no run and frees the input
// a stalled output register holds up the run, which is up to 61 bytes long
// reset clears the fill count, led and pending output; the line store keeps its contents
module serial_command_line_interpreter_core #(
  parameter int LINE_CAPACITY = scli_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_char,
  output logic       last_char,
  output logic       led_state
);

  scli_pkg::ctrl_cmd_t  cmd;
  scli_pkg::dp_status_t status;

  scli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  scli_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_char   (rx_char),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_char   (tx_char),
    .last_char (last_char),
    .led_state (led_state)
  );

  // no new request while a run is still being loaded
  a_idle_no_run: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !status.emit_busy)
    else $error("input ready while a run is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken before the first was handled");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |-> !status.emit_busy)
    else $error("run started over a pending run");

endmodule

// ===== design/scli_ctrl.sv =====
module scli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scli_pkg::dp_status_t status,
  output scli_pkg::ctrl_cmd_t  cmd
);

  scli_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      scli_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_rx = 1'b1;
          state_next  = scli_pkg::ST_DECODE;
        end
      end
      scli_pkg::ST_DECODE: begin
        if (status.is_bs) begin
          if (status.fill_zero) begin
            state_next = scli_pkg::ST_IDLE;
          end else begin
            cmd.erase      = 1'b1;
            cmd.emit_start = 1'b1;
            cmd.emit_msg   = scli_pkg::MSG_ERASE;
            state_next     = scli_pkg::ST_EMIT;
          end
        end else if (status.is_eol) begin
          if (status.fill_zero) begin
            cmd.emit_start = 1'b1;
            cmd.emit_msg   = scli_pkg::MSG_NEWPROMPT;
            state_next     = scli_pkg::ST_EMIT;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = scli_pkg::ST_SCAN_RD;
          end
        end else if (status.room) begin
          cmd.store      = 1'b1;
          cmd.emit_start = 1'b1;
          cmd.emit_msg   = scli_pkg::MSG_ECHO;
          state_next     = scli_pkg::ST_EMIT;
        end else begin
          cmd.clear_fill = 1'b1;
          cmd.emit_start = 1'b1;
          cmd.emit_msg   = scli_pkg::MSG_TOOLONG;
          state_next     = scli_pkg::ST_EMIT;
        end
      end
      scli_pkg::ST_SCAN_RD: begin
        state_next = scli_pkg::ST_SCAN_CHK;
      end
      scli_pkg::ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (status.scan_done) begin
          state_next = scli_pkg::ST_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = scli_pkg::ST_SCAN_RD;
        end
      end
      scli_pkg::ST_RESULT: begin
        cmd.clear_fill = 1'b1;
        cmd.emit_start = 1'b1;
        if (status.match_on) begin
          cmd.led_set  = 1'b1;
          cmd.emit_msg = scli_pkg::MSG_ON;
        end else if (status.match_off) begin
          cmd.led_clr  = 1'b1;
          cmd.emit_msg = scli_pkg::MSG_OFF;
        end else if (status.match_help) begin
          cmd.emit_msg = scli_pkg::MSG_HELP;
        end else begin
          cmd.emit_msg = scli_pkg::MSG_UNKNOWN;
        end
        state_next = scli_pkg::ST_EMIT;
      end
      scli_pkg::ST_EMIT: begin
        if (!status.emit_busy) begin
          state_next = scli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/scli_dp.sv =====
module scli_dp #(
  parameter int LINE_CAPACITY = scli_pkg::LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_char,
  input  scli_pkg::ctrl_cmd_t  cmd,
  output scli_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           tx_char,
  output logic                 last_char,
  output logic                 led_state
);

  localparam int FILL_W = $clog2(LINE_CAPACITY);

  logic [7:0]                  line_store [LINE_CAPACITY];
  logic [7:0]                  rx;
  logic [7:0]                  rd_data;
  logic [FILL_W-1:0]           fill;
  logic                        led;
  logic [scli_pkg::SCAN_W-1:0] si;
  logic                        ok_on, ok_off, ok_help;
  logic [scli_pkg::ROM_AW-1:0] ptr;
  logic [scli_pkg::RUN_W-1:0]  remain;
  logic                        echo;
  logic                        out_free;
  logic                        emit_now;

  always_ff @(posedge clk) begin
    if (cmd.load_rx) begin
      rx <= rx_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_store[fill] <= rx;
    end
    rd_data <= line_store[FILL_W'(si)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      led  <= 1'b0;
    end else begin
      if (cmd.clear_fill) begin
        fill <= '0;
      end else if (cmd.store) begin
        fill <= fill + FILL_W'(1);
      end else if (cmd.erase) begin
        fill <= fill - FILL_W'(1);
      end
      if (cmd.led_set) begin
        led <= 1'b1;
      end else if (cmd.led_clr) begin
        led <= 1'b0;
      end
    end
  end

  // per command match over the first positions of the line
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      si      <= '0;
      ok_on   <= 1'b1;
      ok_off  <= 1'b1;
      ok_help <= 1'b1;
    end else begin
      if (cmd.scan_chk) begin
        if (int'(si) <= scli_pkg::CMD_ON_LEN && rd_data != scli_pkg::CMD_ON_TEXT[si]) begin
          ok_on <= 1'b0;
        end
        if (int'(si) <= scli_pkg::CMD_OFF_LEN && rd_data != scli_pkg::CMD_OFF_TEXT[si]) begin
          ok_off <= 1'b0;
        end
        if (int'(si) <= scli_pkg::CMD_HELP_LEN &&
            rd_data != scli_pkg::CMD_HELP_TEXT[si]) begin
          ok_help <= 1'b0;
        end
      end
      if (cmd.scan_next) begin
        si <= si + scli_pkg::SCAN_W'(1);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit_now = (remain != '0) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.emit_start) begin
      remain <= scli_pkg::msg_len(cmd.emit_msg);
    end else if (emit_now) begin
      remain <= remain - scli_pkg::RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      ptr  <= scli_pkg::msg_offset(cmd.emit_msg);
      echo <= (cmd.emit_msg == scli_pkg::MSG_ECHO);
    end else if (emit_now) begin
      ptr <= ptr + scli_pkg::ROM_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      tx_char   <= echo ? rx : scli_pkg::rom_byte(ptr);
      last_char <= (remain == scli_pkg::RUN_W'(1));
      led_state <= led;
    end
  end

  always_comb begin
    status            = '0;
    status.is_bs      = (rx == scli_pkg::CH_BS) || (rx == scli_pkg::CH_DEL);
    status.is_eol     = (rx == scli_pkg::CH_CR) || (rx == scli_pkg::CH_LF);
    status.fill_zero  = (fill == '0);
    status.room       = (fill < FILL_W'(LINE_CAPACITY - 1));
    status.scan_done  = (si == scli_pkg::SCAN_W'(scli_pkg::SCAN_MAX - 1)) ||
                        (FILL_W'(si) + FILL_W'(1) == fill);
    status.match_on   = ok_on && (fill >= FILL_W'(scli_pkg::CMD_ON_LEN));
    status.match_off  = ok_off && (fill >= FILL_W'(scli_pkg::CMD_OFF_LEN));
    status.match_help = ok_help && (fill >= FILL_W'(scli_pkg::CMD_HELP_LEN));
    status.emit_busy  = (remain != '0);
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       led;
  } reply_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_char = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_char;
  logic       last_char;
  logic       led_state;

  serial_command_line_interpreter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_char   (rx_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_char   (tx_char),
    .last_char (last_char),
    .led_state (led_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("serial_command_line_interpreter_core: mismatch");
    $finish;
  end

  // line state as the block should hold it
  logic [7:0]  line_buf [scli_pkg::LINE_CAPACITY_DEF];
  int          line_fill = 0;
  logic        led_on = 1'b0;
  logic [7:0]  run_bytes [$];
  reply_byte_t reply_q [$];

  int fails = 0;
  int sent_items = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  logic [7:0] tab_rx [32];
  int         tab_count [32];
  bit         tab_typed [32];
  string      tab_reply [32];
  int         tab_rows = 0;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    fails++;
  endtask

  function automatic bit line_is(input string cmd);
    int k;
    k = 0;
    while (k < line_fill && line_buf[k] != 8'h00) k++;
    if (k != cmd.len()) return 1'b0;
    for (int i = 0; i < k; i++) begin
      if (line_buf[i] != cmd[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) run_bytes.push_back(s[i]);
  endtask

  task automatic interpret_byte(input logic [7:0] b);
    run_bytes.delete();
    if (b == scli_pkg::CH_BS || b == scli_pkg::CH_DEL) begin
      if (line_fill > 0) begin
        line_fill--;
        append_text("\010 \010");
      end
    end else if (b == scli_pkg::CH_CR || b == scli_pkg::CH_LF) begin
      if (line_fill > 0) begin
        if (line_is("LED_ON")) begin
          led_on = 1'b1;
          append_text("\015\012OK: LED ON\015\012");
        end else if (line_is("LED_OFF")) begin
          led_on = 1'b0;
          append_text("\015\012OK: LED OFF\015\012");
        end else if (line_is("HELP")) begin
          append_text({"\015\012--- MENU ---\015\012LED_ON\015\012LED_OFF\015\012",
                       "HELP\015\012------------\015\012"});
        end else begin
          append_text("\015\012ERROR: Unknown command\015\012");
        end
        line_fill = 0;
        append_text("Ready > ");
      end else begin
        append_text("\015\012Ready > ");
      end
    end else if (line_fill < scli_pkg::LINE_CAPACITY_DEF - 1) begin
      run_bytes.push_back(b);
      line_buf[line_fill] = b;
      line_fill++;
    end else begin
      append_text("\015\012ERROR: Too long!\015\012Ready > ");
      line_fill = 0;
    end
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input string reply = "");
    int gap;
    bit ignored;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_char  <= b;
    do @(posedge clk); while (in_stall);
    ignored = (b == scli_pkg::CH_BS || b == scli_pkg::CH_DEL) && line_fill == 0;
    interpret_byte(b);
    if (typed) begin
      run_bytes.delete();
      append_text(reply);
    end
    for (int i = 0; i < run_bytes.size(); i++)
      reply_q.push_back('{tx: run_bytes[i], last: (i == run_bytes.size() - 1), led: led_on});
    if (!ignored) sent_items++;
    @(negedge clk);
  endtask

  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] b, input int count, input bit typed = 1'b0,
                         input string reply = "");
    tab_rx[tab_rows]    = b;
    tab_count[tab_rows] = count;
    tab_typed[tab_rows] = typed;
    tab_reply[tab_rows] = reply;
    tab_rows++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_random_line();
    int kind;
    int n;
    string word;
    logic [7:0] eol;
    calm = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 9);
    eol  = $urandom_range(0, 1) ? scli_pkg::CH_CR : scli_pkg::CH_LF;
    if (kind < 5) begin
      case ($urandom_range(0, 2))
        0:       word = "LED_ON";
        1:       word = "LED_OFF";
        default: word = "HELP";
      endcase
      for (int i = 0; i < word.len(); i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_byte(8'($urandom_range(32, 126)));
          send_byte($urandom_range(0, 1) ? scli_pkg::CH_BS : scli_pkg::CH_DEL);
        end
        if ($urandom_range(0, 24) == 0)
          send_byte(word[i] ^ 8'(1 << $urandom_range(0, 7)));
        else
          send_byte(word[i]);
      end
      case ($urandom_range(0, 5))
        0: begin
          // zero byte cuts the text, junk after it must not matter
          send_byte(8'h00);
          n = $urandom_range(0, 3);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        1: send_byte(8'($urandom_range(32, 126)));
        2: send_byte($urandom_range(0, 1) ? scli_pkg::CH_BS : scli_pkg::CH_DEL);
        default: ;
      endcase
      send_byte(eol);
    end else if (kind < 7) begin
      n = $urandom_range(0, 14);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      send_byte(eol);
    end else if (kind < 8) begin
      n = $urandom_range(15, 18);
      repeat (n) send_byte(8'($urandom_range(32, 126)));
      send_byte(eol);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result checking
  always @(posedge clk) begin
    reply_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", tx_char));
      end else begin
        want = reply_q.pop_front();
        if (tx_char !== want.tx)
          report_mismatch($sformatf("tx_char got %02h want %02h", tx_char, want.tx));
        if (last_char !== want.last)
          report_mismatch($sformatf("last_char got %b want %b on %02h",
                                    last_char, want.last, want.tx));
        if (led_state !== want.led)
          report_mismatch($sformatf("led_state got %b want %b on %02h",
                                    led_state, want.led, want.tx));
      end
      stall_left = draw_wait();
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int next_drain;
    int waited;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_row(scli_pkg::CH_BS, 1, 1'b1, "");
    add_row(scli_pkg::CH_DEL, 1, 1'b1, "");
    add_row(scli_pkg::CH_CR, 1, 1'b1, "\015\012Ready > ");
    add_row(scli_pkg::CH_LF, 1, 1'b1, "\015\012Ready > ");
    add_row("L", 1);
    add_row("E", 1);
    add_row("D", 1);
    add_row("_", 1);
    add_row("O", 1);
    add_row("N", 1);
    add_row(scli_pkg::CH_CR, 1, 1'b1, "\015\012OK: LED ON\015\012Ready > ");
    add_row("L", 1);
    add_row("E", 1);
    add_row("D", 1);
    add_row("_", 1);
    add_row("O", 1);
    add_row("F", 1);
    add_row("F", 1);
    add_row(scli_pkg::CH_LF, 1, 1'b1, "\015\012OK: LED OFF\015\012Ready > ");
    add_row("H", 1);
    add_row("E", 1);
    add_row("L", 1);
    add_row("P", 1);
    add_row(scli_pkg::CH_CR, 1);
    add_row(8'hFF, 15);
    add_row(8'h00, 1, 1'b1, "\015\012ERROR: Too long!\015\012Ready > ");
    add_row(8'h00, 1);
    add_row(scli_pkg::CH_DEL, 1, 1'b1, "\010 \010");
    add_row(8'h00, 1);
    add_row(scli_pkg::CH_CR, 1, 1'b1, "\015\012ERROR: Unknown command\015\012Ready > ");

    for (int r = 0; r < tab_rows; r++) begin
      repeat (tab_count[r]) send_byte(tab_rx[r], tab_typed[r], tab_reply[r]);
    end
    wait_replies_drained();

    next_drain = sent_items + 100;
    while (sent_items < 530) begin
      send_random_line();
      if (sent_items >= next_drain) begin
        wait_replies_drained();
        next_drain = sent_items + 100;
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (reply_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    if (reply_q.size() != 0)
      report_mismatch($sformatf("%0d reply bytes never came", reply_q.size()));

    if (fails == 0) begin
      $display("serial_command_line_interpreter_core: match");
    end else begin
      $display("serial_command_line_interpreter_core: mismatch");
    end
    $finish;
  end

endmodule
